>>> rtl/affine_matrix_trs_decompose_assert.svh
// Assertion macros used by the affine_matrix_trs_decompose module.
`ifndef AFFINE_MATRIX_TRS_DECOMPOSE_ASSERT_SVH
`define AFFINE_MATRIX_TRS_DECOMPOSE_ASSERT_SVH

// Checks that an implication holds on every clock edge outside reset.
`define AMTD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that an implication holds in the cycle after the antecedent.
`define AMTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/amtd_pkg.sv
package amtd_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned InDataW = 12 * WordW;
  localparam int unsigned OutDataW = 10 * WordW;
  localparam int unsigned SqrtInW = 66;
  localparam int unsigned SqrtOutW = 33;
  localparam int unsigned SqrtSteps = SqrtOutW;
  localparam int unsigned DivNumW = 63;
  localparam int unsigned DivSteps = DivNumW;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

  localparam logic [1:0] DiagW = 2'd0;
  localparam logic [1:0] DiagX = 2'd1;
  localparam logic [1:0] DiagY = 2'd2;
  localparam logic [1:0] DiagZ = 2'd3;

  typedef struct packed {
    logic [SqrtInW-1:0]  rem;
    logic [SqrtOutW-1:0] root;
    logic [SqrtInW-1:0]  val;
  } sqrt_state_t;

  typedef struct packed {
    logic [DivNumW-1:0] num;
    logic [DivNumW:0]   rem;
    logic [DivNumW-1:0] quo;
    logic [33:0]        den;
    logic               neg;
  } div_state_t;

  function automatic sqrt_state_t sqrt_step(sqrt_state_t st, int unsigned idx);
    sqrt_state_t o;
    logic [SqrtInW-1:0] trial;
    logic [SqrtInW-1:0] cur;
    o = st;
    cur = {st.rem[SqrtInW-3:0], st.val[SqrtInW-1 -: 2]};
    trial = {st.root[SqrtOutW-2:0], 2'b01};
    o.val = {st.val[SqrtInW-3:0], 2'b00};
    if (cur >= trial) begin
      o.rem = cur - trial;
      o.root = {st.root[SqrtOutW-2:0], 1'b1};
    end else begin
      o.rem = cur;
      o.root = {st.root[SqrtOutW-2:0], 1'b0};
    end
    if (idx > SqrtSteps) o = st;
    return o;
  endfunction

  function automatic div_state_t div_step(div_state_t st);
    div_state_t o;
    logic [DivNumW:0] cur;
    o = st;
    cur = {st.rem[DivNumW-1:0], st.num[DivNumW-1]};
    o.num = {st.num[DivNumW-2:0], 1'b0};
    if (cur >= {{(DivNumW-33){1'b0}}, st.den}) begin
      o.rem = cur - {{(DivNumW-33){1'b0}}, st.den};
      o.quo = {st.quo[DivNumW-2:0], 1'b1};
    end else begin
      o.rem = cur;
      o.quo = {st.quo[DivNumW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

>>> rtl/affine_matrix_trs_decompose.sv
// Affine TRS decomposition. A word on the in_ channel carries the upper 3x4
// part of a column-major matrix (twelve signed Q16.16 elements); one word on
// the out_ channel follows per input word, with translation, quaternion
// (signed Q2.30) and per-axis scale (unsigned Q16.16).
// The block is a single pipeline: a register for the column squares, column
// lengths by a 33-stage square root, column normalization by a 63-stage
// divider, a register for the normalized matrix, Shepperd branching into a
// second 33-stage square root, a second 63-stage divider for the quaternion,
// and the output register. One word is accepted every cycle unless stalled.
// The whole pipeline advances unless a word waits in the output register
// while the receiver holds out_tready low; then the pipeline freezes and
// in_tready is low, so no word is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
module affine_matrix_trs_decompose (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2, c2_r0, c2_r1, c2_r2, c3_r0, c3_r1, c3_r2
  input  logic [amtd_pkg::InDataW-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // trans_x, trans_y, trans_z, quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z
  output logic [amtd_pkg::OutDataW-1:0] out_tdata
);
  import amtd_pkg::*;
  `include "affine_matrix_trs_decompose_assert.svh"

  localparam int unsigned Tag1 = 1 + InDataW;
  localparam int unsigned TagR = 1 + 3 * WordW + 3 * 32 + 2 + 3 * 34;
  localparam int unsigned Tag3 = TagR - 3 * 34 + 33;

  logic stall;
  logic out_valid_r;
  logic [OutDataW-1:0] out_data_r;

  assign stall = out_valid_r && !out_tready;
  assign in_tready = !stall;

  // Stage A: squares per column.
  logic [SqrtInW-1:0] sum_nxt [3];
  logic [SqrtInW-1:0] sum_r [3];
  logic v_a_r;
  logic [InDataW-1:0] d_a_r;
  logic [31:0] mg;
  logic [63:0] sq;
  logic [Tag1-1:0] tag1_in;
  always_comb begin
    mg = '0;
    sq = '0;
    for (int j = 0; j < 3; j++) begin
      sum_nxt[j] = '0;
      for (int i = 0; i < 3; i++) begin
        mg = in_tdata[(3*j+i)*32 + 31] ? 32'd0 - in_tdata[(3*j+i)*32 +: 32] :
                                         in_tdata[(3*j+i)*32 +: 32];
        sq = 64'(mg) * 64'(mg);
        sum_nxt[j] = sum_nxt[j] + SqrtInW'(sq);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else if (!stall) begin
      v_a_r <= in_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (!stall) begin
      d_a_r <= in_tdata;
      sum_r <= sum_nxt;
    end
  end
  assign tag1_in = {v_a_r, d_a_r};

  logic [SqrtOutW-1:0] s_root [3];
  logic [Tag1-1:0] tag1_out [3];
  for (genvar j = 0; j < 3; j++) begin : g_sq1
    amtd_sqrt_pipe #(.Tag(Tag1)) u_sq (.clk(clk), .rst_n(rst_n), .stall(stall),
      .in_val(sum_r[j]), .in_tag(tag1_in), .out_root(s_root[j]), .out_tag(tag1_out[j]));
  end

  // Stage B: normalize nine elements.
  logic [Tag1-1:0] t1;
  logic [DivNumW-1:0] nq [9];
  logic nn [9];
  logic nz [9];
  logic [Tag1-1:0] t2 [9];
  assign t1 = tag1_out[0];
  for (genvar e = 0; e < 9; e++) begin : g_nd
    amtd_div_pipe #(.Tag(Tag1)) u_dv (.clk(clk), .rst_n(rst_n), .stall(stall),
      .in_num(34'($signed(t1[e*32 +: 32]))), .in_den({1'b0, s_root[e/3]}),
      .in_tag(t1), .out_quo(nq[e]), .out_neg(nn[e]), .out_zero(nz[e]), .out_tag(t2[e]));
  end
  logic [31:0] sc_d [3];
  for (genvar j = 0; j < 3; j++) begin : g_scd
    logic [31:0] sh_r [DivSteps];
    always_ff @(posedge clk) begin
      if (!stall) begin
        sh_r[0] <= s_root[j][32] ? 32'hFFFFFFFF : s_root[j][31:0];
        for (int k = 1; k < DivSteps; k++) sh_r[k] <= sh_r[k-1];
      end
    end
    assign sc_d[j] = sh_r[DivSteps-1];
  end

  // Stage C: clamp and register the normalized matrix.
  logic signed [31:0] r_r [9];
  logic v_c_r;
  logic [InDataW-1:0] d_c_r;
  logic [95:0] sc_c_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c_r <= 1'b0;
    end else if (!stall) begin
      v_c_r <= t2[0][Tag1-1];
    end
  end
  always_ff @(posedge clk) begin
    if (!stall) begin
      d_c_r <= t2[0][InDataW-1:0];
      sc_c_r <= {sc_d[2], sc_d[1], sc_d[0]};
      for (int e = 0; e < 9; e++) begin
        if (nz[e]) r_r[e] <= '0;
        else if (nq[e] > DivNumW'(1 << 30)) r_r[e] <= nn[e] ? -32'sd1073741824 : 32'sd1073741824;
        else r_r[e] <= nn[e] ? -$signed(nq[e][31:0]) : $signed(nq[e][31:0]);
      end
    end
  end

  // Stage D: Shepperd branch. r_r index = col*3+row.
  logic signed [33:0] r00, r11, r22, r01, r10, r02, r20, r12, r21, tr, a_v;
  logic signed [33:0] n1, n2, n3;
  logic [1:0] diag;
  always_comb begin
    r00 = 34'(r_r[0]); r10 = 34'(r_r[1]); r20 = 34'(r_r[2]);
    r01 = 34'(r_r[3]); r11 = 34'(r_r[4]); r21 = 34'(r_r[5]);
    r02 = 34'(r_r[6]); r12 = 34'(r_r[7]); r22 = 34'(r_r[8]);
    tr = r00 + r11 + r22;
    if (tr > 0) begin
      diag = DiagW; a_v = OneQ30 + tr;
      n1 = r21 - r12; n2 = r02 - r20; n3 = r10 - r01;
    end else if (r00 > r11 && r00 > r22) begin
      diag = DiagX; a_v = OneQ30 + r00 - r11 - r22;
      n1 = r21 - r12; n2 = r01 + r10; n3 = r02 + r20;
    end else if (r11 > r22) begin
      diag = DiagY; a_v = OneQ30 + r11 - r00 - r22;
      n1 = r02 - r20; n2 = r01 + r10; n3 = r12 + r21;
    end else begin
      diag = DiagZ; a_v = OneQ30 + r22 - r00 - r11;
      n1 = r10 - r01; n2 = r02 + r20; n3 = r12 + r21;
    end
    if (a_v < 0) a_v = '0;
  end

  logic [TagR-1:0] tagr_in;
  logic [SqrtInW-1:0] a_sh;
  assign tagr_in = {v_c_r, d_c_r[InDataW-1 -: 96], sc_c_r, diag, n3, n2, n1};
  assign a_sh = SqrtInW'({a_v[32:0], 30'd0});

  logic [SqrtOutW-1:0] h_root;
  logic [TagR-1:0] tagr_out;
  amtd_sqrt_pipe #(.Tag(TagR)) u_sq2 (.clk(clk), .rst_n(rst_n), .stall(stall), .in_val(a_sh),
    .in_tag(tagr_in), .out_root(h_root), .out_tag(tagr_out));

  // Stage E: quotient components.
  logic [Tag3-1:0] tag3_in;
  logic [DivNumW-1:0] qq [3];
  logic qn [3];
  logic qz [3];
  logic [Tag3-1:0] tag3_out [3];
  assign tag3_in = {tagr_out[TagR-1:3*34], h_root};
  for (genvar c = 0; c < 3; c++) begin : g_qd
    amtd_div_pipe #(.Tag(Tag3)) u_dq (.clk(clk), .rst_n(rst_n), .stall(stall),
      .in_num(tagr_out[c*34 +: 34]), .in_den({h_root, 1'b0}),
      .in_tag(tag3_in), .out_quo(qq[c]), .out_neg(qn[c]), .out_zero(qz[c]),
      .out_tag(tag3_out[c]));
  end

  // Output register: saturate and place components.
  logic [31:0] oth [3];
  logic [31:0] qv [4];
  logic [1:0] dg;
  logic [32:0] hh;
  logic [95:0] tr_o;
  logic [95:0] sc_o;
  always_comb begin
    hh = tag3_out[0][32:0];
    dg = tag3_out[0][34:33];
    sc_o = tag3_out[0][130:35];
    tr_o = tag3_out[0][226:131];
    for (int c = 0; c < 3; c++) begin
      if (qz[c]) oth[c] = '0;
      else if (qn[c]) oth[c] = (qq[c] > DivNumW'(32'h80000000)) ? 32'h80000000 :
                               32'(-qq[c][31:0]);
      else oth[c] = (qq[c] > DivNumW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : qq[c][31:0];
    end
    case (dg)
      DiagW: qv = '{hh[32:1], oth[0], oth[1], oth[2]};
      DiagX: qv = '{oth[0], hh[32:1], oth[1], oth[2]};
      DiagY: qv = '{oth[0], oth[1], hh[32:1], oth[2]};
      default: qv = '{oth[0], oth[1], oth[2], hh[32:1]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!stall) begin
      out_valid_r <= tag3_out[0][Tag3-1];
    end
  end
  always_ff @(posedge clk) begin
    if (!stall) begin
      out_data_r <= {sc_o, qv[3], qv[2], qv[1], qv[0], tr_o};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  `AMTD_ASSERT_IMPL(a_ready_when_free, clk, rst_n, !out_valid_r, in_tready)
  `AMTD_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_valid_r && !out_tready,
                    out_valid_r && $stable(out_data_r))
  `AMTD_ASSERT_IMPL(a_stall_blocks_input, clk, rst_n, out_valid_r && !out_tready, !in_tready)
endmodule

>>> rtl/amtd_sqrt_pipe.sv
module amtd_sqrt_pipe #(
  parameter int unsigned Tag = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           stall,
  input  logic [amtd_pkg::SqrtInW-1:0]   in_val,
  input  logic [Tag-1:0]                 in_tag,
  output logic [amtd_pkg::SqrtOutW-1:0]  out_root,
  output logic [Tag-1:0]                 out_tag
);
  import amtd_pkg::*;

  // The top bit of a tag is the valid bit, and only that bit is cleared at reset.
  sqrt_state_t st_in;

  assign st_in = '{rem: '0, root: '0, val: in_val};

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_st
    sqrt_state_t st_r;
    logic [Tag-2:0] tag_r;
    logic vld_r;
    sqrt_state_t prev_st;
    logic [Tag-2:0] prev_tag;
    logic prev_vld;
    if (g == 0) begin : g_src
      assign prev_st = st_in;
      assign prev_tag = in_tag[Tag-2:0];
      assign prev_vld = in_tag[Tag-1];
    end else begin : g_src
      assign prev_st = g_st[g-1].st_r;
      assign prev_tag = g_st[g-1].tag_r;
      assign prev_vld = g_st[g-1].vld_r;
    end
    always_ff @(posedge clk) begin
      if (!stall) begin
        st_r <= sqrt_step(prev_st, g);
        tag_r <= prev_tag;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (!stall) begin
        vld_r <= prev_vld;
      end
    end
  end

  assign out_root = g_st[SqrtSteps-1].st_r.root;
  assign out_tag = {g_st[SqrtSteps-1].vld_r, g_st[SqrtSteps-1].tag_r};
endmodule

>>> rtl/amtd_div_pipe.sv
module amtd_div_pipe #(
  parameter int unsigned Tag = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               stall,
  input  logic signed [33:0] in_num,
  input  logic [33:0]        in_den,
  input  logic [Tag-1:0]     in_tag,
  output logic [amtd_pkg::DivNumW-1:0] out_quo,
  output logic               out_neg,
  output logic               out_zero,
  output logic [Tag-1:0]     out_tag
);
  import amtd_pkg::*;

  // The top bit of a tag is the valid bit, and only that bit is cleared at reset.
  div_state_t st_in;
  logic [32:0] mag;

  always_comb begin
    mag = in_num[33] ? 33'(-in_num) : in_num[32:0];
    st_in = '{num: {mag[32:0], 30'd0}, rem: '0, quo: '0, den: in_den,
              neg: in_num[33]};
  end

  for (genvar g = 0; g < DivSteps; g++) begin : g_st
    div_state_t st_r;
    logic [Tag-2:0] tag_r;
    logic vld_r;
    div_state_t prev_st;
    logic [Tag-2:0] prev_tag;
    logic prev_vld;
    if (g == 0) begin : g_src
      assign prev_st = st_in;
      assign prev_tag = in_tag[Tag-2:0];
      assign prev_vld = in_tag[Tag-1];
    end else begin : g_src
      assign prev_st = g_st[g-1].st_r;
      assign prev_tag = g_st[g-1].tag_r;
      assign prev_vld = g_st[g-1].vld_r;
    end
    always_ff @(posedge clk) begin
      if (!stall) begin
        st_r <= div_step(prev_st);
        tag_r <= prev_tag;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (!stall) begin
        vld_r <= prev_vld;
      end
    end
  end

  assign out_quo = g_st[DivSteps-1].st_r.quo;
  assign out_neg = g_st[DivSteps-1].st_r.neg;
  assign out_zero = (g_st[DivSteps-1].st_r.den == '0);
  assign out_tag = {g_st[DivSteps-1].vld_r, g_st[DivSteps-1].tag_r};
endmodule
